### rtl/assert_macros.svh
// Assertion macros shared by the access matrix engine RTL.
// Every macro expects a clock named clk in scope; AMX_ASSERT also expects an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define AMX_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define AMX_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/amx_pkg.sv
// Shared constants, codes, types and helpers for the access matrix engine.
// It depends on nothing. Every RTL module imports it.
package amx_pkg;

    localparam int MAX_SUBJECTS = 16;
    localparam int MAX_OBJECTS  = 16;
    localparam int ID_WIDTH     = 16;

    localparam int FIELD_ID_W = 16;
    localparam int RIGHTS_W   = 4;
    localparam int STATUS_W   = 3;
    localparam int MODE_W     = 3;

    localparam int SUBJ_IW  = (MAX_SUBJECTS > 1) ? $clog2(MAX_SUBJECTS) : 1;
    localparam int OBJ_IW   = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int SUBJ_CW  = $clog2(MAX_SUBJECTS + 1);
    localparam int OBJ_CW   = $clog2(MAX_OBJECTS + 1);
    localparam int SWEEP_IW = (SUBJ_IW > OBJ_IW) ? SUBJ_IW : OBJ_IW;

    localparam int CELLS   = MAX_SUBJECTS * MAX_OBJECTS;
    localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;

    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_CREATE_OBJ  = 3'd0,
        MODE_CREATE_SUBJ = 3'd1,
        MODE_DESTROY_OBJ = 3'd2,
        MODE_DESTROY_SUBJ = 3'd3,
        MODE_ENTER       = 3'd4,
        MODE_DELETE      = 3'd5,
        MODE_CHECK       = 3'd6
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_NO_SUBJ = 3'd1,
        STAT_NO_OBJ  = 3'd2,
        STAT_EXISTS  = 3'd3,
        STAT_FULL    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GUARD,
        S_GWAIT,
        S_EXEC,
        S_CELL,
        S_CLEAR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic               hit;
        logic [SUBJ_IW-1:0] idx;
    } subj_lu_t;

    typedef struct packed {
        logic              hit;
        logic [OBJ_IW-1:0] idx;
    } obj_lu_t;

    // Row-major cell address: subject row, object column.
    function automatic logic [CELL_AW-1:0] cell_addr(input logic [SUBJ_IW-1:0] s,
                                                    input logic [OBJ_IW-1:0] o);
        logic [CELL_AW-1:0] row_base;
        row_base = CELL_AW'(CELL_AW'(s) * CELL_AW'(MAX_OBJECTS));
        return CELL_AW'(row_base + CELL_AW'(o));
    endfunction

endpackage

### rtl/amx_id_tables.sv
// Subject and object id tables with fill counts and parallel lookup.
// Depends on amx_pkg and assert_macros.svh.
`include "assert_macros.svh"

module amx_id_tables (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [amx_pkg::ID_WIDTH-1:0]   subj_key,
    input  logic [amx_pkg::ID_WIDTH-1:0]   obj_key,
    input  logic                           subj_wr,
    input  logic                           obj_wr,
    output amx_pkg::subj_lu_t              subj_lu,
    output amx_pkg::obj_lu_t               obj_lu,
    output logic                           subj_full,
    output logic                           obj_full,
    output logic [amx_pkg::SUBJ_IW-1:0]    subj_new_idx,
    output logic [amx_pkg::OBJ_IW-1:0]     obj_new_idx
);
    import amx_pkg::*;

    logic [ID_WIDTH-1:0] subj_ids_reg [MAX_SUBJECTS];
    logic [ID_WIDTH-1:0] obj_ids_reg  [MAX_OBJECTS];
    logic [SUBJ_CW-1:0]  subj_count_reg, subj_count_next;
    logic [OBJ_CW-1:0]   obj_count_reg, obj_count_next;

    // Only entries below the fill count take part in a lookup.
    always_comb
    begin
        subj_lu = '0;
        for (int k = MAX_SUBJECTS - 1; k >= 0; k--)
        begin
            if (SUBJ_CW'(k) < subj_count_reg && subj_ids_reg[k] == subj_key)
            begin
                subj_lu.hit = 1'b1;
                subj_lu.idx = SUBJ_IW'(k);
            end
        end
    end

    always_comb
    begin
        obj_lu = '0;
        for (int k = MAX_OBJECTS - 1; k >= 0; k--)
        begin
            if (OBJ_CW'(k) < obj_count_reg && obj_ids_reg[k] == obj_key)
            begin
                obj_lu.hit = 1'b1;
                obj_lu.idx = OBJ_IW'(k);
            end
        end
    end

    assign subj_full       = (subj_count_reg == SUBJ_CW'(MAX_SUBJECTS));
    assign obj_full        = (obj_count_reg == OBJ_CW'(MAX_OBJECTS));
    assign subj_new_idx    = SUBJ_IW'(subj_count_reg);
    assign obj_new_idx     = OBJ_IW'(obj_count_reg);
    assign subj_count_next = subj_wr ? SUBJ_CW'(subj_count_reg + 1'b1) : subj_count_reg;
    assign obj_count_next  = obj_wr ? OBJ_CW'(obj_count_reg + 1'b1) : obj_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subj_count_reg <= '0;
            obj_count_reg  <= '0;
        end
        else
        begin
            subj_count_reg <= subj_count_next;
            obj_count_reg  <= obj_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (subj_wr)
        begin
            subj_ids_reg[subj_new_idx] <= subj_key;
        end
        if (obj_wr)
        begin
            obj_ids_reg[obj_new_idx] <= obj_key;
        end
    end

    `AMX_ASSERT_ALWAYS(a_subj_count_max, subj_count_reg <= SUBJ_CW'(MAX_SUBJECTS), "subject count overflow")
    `AMX_ASSERT_ALWAYS(a_obj_count_max, obj_count_reg <= OBJ_CW'(MAX_OBJECTS), "object count overflow")
    `AMX_ASSERT(a_no_write_when_full, !(subj_wr && subj_full) && !(obj_wr && obj_full), "write into full table")

endmodule

### rtl/amx_rights_ram.sv
// Rights matrix memory: one 4-bit cell per subject and object pair.
// One write port and one read port with registered read data. Depends on amx_pkg.
module amx_rights_ram (
    input  logic                          clk,
    input  logic                          re,
    input  logic [amx_pkg::CELL_AW-1:0]   raddr,
    output logic [amx_pkg::RIGHTS_W-1:0]  rdata,
    input  logic                          we,
    input  logic [amx_pkg::CELL_AW-1:0]   waddr,
    input  logic [amx_pkg::RIGHTS_W-1:0]  wdata
);
    import amx_pkg::*;

    logic [RIGHTS_W-1:0] mem [CELLS];
    logic [RIGHTS_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/access_matrix_engine_core.sv
// Top level of the access matrix engine: command sequencer around the id tables
// and the rights memory. Depends on amx_pkg, amx_id_tables, amx_rights_ram.
//
//   Port group   Dir  Payload (low bit first)
//   s_axis_*     in   mode, subject_id, object_id, right_mask, guard_on, guard_right,
//                     guard_subject_id, guard_object_id
//   m_axis_*     out  status, granted, skipped, cell_rights
//
// Enter, delete and check use S_EXEC and S_CELL; a guard adds S_GUARD and S_GWAIT.
// Create and destroy sweep S_CLEAR: one rights memory write per cell of the row or
// column (MAX_OBJECTS or MAX_SUBJECTS writes of the single write port).
// The next command is taken once the current one has reached the output register.
// Reset empties both id tables; the rights memory needs no clearing pass.
`include "assert_macros.svh"

module access_matrix_engine_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // mode[2:0], subject_id[18:3], object_id[34:19], right_mask[38:35], guard_on[39],
    // guard_right[43:40], guard_subject_id[59:44], guard_object_id[75:60], zeros above
    input  logic [amx_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // status[2:0], granted[3], skipped[4], cell_rights[8:5], zeros above
    output logic [amx_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import amx_pkg::*;

    state_t state_reg, state_next;

    logic [MODE_W-1:0]     mode_reg;
    logic [ID_WIDTH-1:0]   sid_reg, oid_reg, gsid_reg, goid_reg;
    logic [RIGHTS_W-1:0]   mask_reg, gright_reg;
    logic                  gon_reg;

    logic [MODE_W-1:0]     in_mode;
    logic                  accept;

    logic [STATUS_W-1:0]   status_reg, status_next;
    logic                  granted_reg, granted_next;
    logic                  skipped_reg, skipped_next;
    logic [RIGHTS_W-1:0]   cell_reg, cell_next;
    logic [SWEEP_IW-1:0]   sweep_reg, sweep_next;
    logic [SWEEP_IW-1:0]   tgt_reg, tgt_next;
    logic                  row_reg, row_next;
    logic [CELL_AW-1:0]    caddr_reg, caddr_next;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                  out_load;

    logic [ID_WIDTH-1:0]   subj_key, obj_key;
    subj_lu_t              subj_lu;
    obj_lu_t               obj_lu;
    logic                  subj_full, obj_full, subj_wr, obj_wr;
    logic [SUBJ_IW-1:0]    subj_new_idx;
    logic [OBJ_IW-1:0]     obj_new_idx;

    logic                  ram_re, ram_we;
    logic [CELL_AW-1:0]    ram_raddr, ram_waddr, pair_addr;
    logic [RIGHTS_W-1:0]   ram_rdata, ram_wdata;

    logic                  pair_hit, exec_clear, exec_cell, sweep_last, is_cell_mode;

    assign in_mode = s_axis_tdata[2:0];
    assign accept  = s_axis_tvalid && s_axis_tready;

    // The guard looks up its own pair; every other state uses the command ids.
    assign subj_key = (state_reg == S_GUARD) ? gsid_reg : sid_reg;
    assign obj_key  = (state_reg == S_GUARD) ? goid_reg : oid_reg;

    amx_id_tables u_ids (
        .clk          (clk),
        .rst_n        (rst_n),
        .subj_key     (subj_key),
        .obj_key      (obj_key),
        .subj_wr      (subj_wr),
        .obj_wr       (obj_wr),
        .subj_lu      (subj_lu),
        .obj_lu       (obj_lu),
        .subj_full    (subj_full),
        .obj_full     (obj_full),
        .subj_new_idx (subj_new_idx),
        .obj_new_idx  (obj_new_idx)
    );

    amx_rights_ram u_ram (
        .clk   (clk),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata)
    );

    assign pair_hit     = subj_lu.hit && obj_lu.hit;
    assign pair_addr    = cell_addr(subj_lu.idx, obj_lu.idx);
    assign is_cell_mode = (mode_reg == MODE_ENTER) || (mode_reg == MODE_DELETE)
                          || (mode_reg == MODE_CHECK);
    assign exec_cell    = is_cell_mode && pair_hit;
    assign sweep_last   = row_reg ? (sweep_reg == SWEEP_IW'(MAX_OBJECTS - 1))
                                  : (sweep_reg == SWEEP_IW'(MAX_SUBJECTS - 1));
    assign out_load     = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        case (mode_reg)
            MODE_CREATE_OBJ:   exec_clear = !obj_lu.hit && !obj_full;
            MODE_CREATE_SUBJ:  exec_clear = !subj_lu.hit && !subj_full;
            MODE_DESTROY_OBJ:  exec_clear = obj_lu.hit;
            MODE_DESTROY_SUBJ: exec_clear = subj_lu.hit;
            default:           exec_clear = 1'b0;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_mode > MODE_CHECK)
                        state_next = S_DONE;
                    else if (s_axis_tdata[39])
                        state_next = S_GUARD;
                    else
                        state_next = S_EXEC;
                end
            end
            S_GUARD: state_next = pair_hit ? S_GWAIT : S_DONE;
            S_GWAIT: state_next = ((ram_rdata & gright_reg) != '0) ? S_EXEC : S_DONE;
            S_EXEC:
            begin
                if (exec_clear)
                    state_next = S_CLEAR;
                else if (exec_cell)
                    state_next = S_CELL;
                else
                    state_next = S_DONE;
            end
            S_CELL:  state_next = S_DONE;
            S_CLEAR: state_next = sweep_last ? S_DONE : S_CLEAR;
            S_DONE:  state_next = out_load ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs and datapath controls.
    always_comb
    begin
        s_axis_tready = 1'b0;
        subj_wr       = 1'b0;
        obj_wr        = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = pair_addr;
        ram_we        = 1'b0;
        ram_waddr     = caddr_reg;
        ram_wdata     = '0;
        status_next   = status_reg;
        granted_next  = granted_reg;
        skipped_next  = skipped_reg;
        cell_next     = cell_reg;
        sweep_next    = sweep_reg;
        tgt_next      = tgt_reg;
        row_next      = row_reg;
        caddr_next    = caddr_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                status_next   = STAT_OK;
                granted_next  = 1'b0;
                skipped_next  = 1'b0;
                cell_next     = '0;
                sweep_next    = '0;
            end
            S_GUARD:
            begin
                if (!subj_lu.hit)
                begin
                    status_next  = STAT_NO_SUBJ;
                    skipped_next = 1'b1;
                end
                else if (!obj_lu.hit)
                begin
                    status_next  = STAT_NO_OBJ;
                    skipped_next = 1'b1;
                end
                else
                begin
                    ram_re = 1'b1;
                end
            end
            S_GWAIT:
            begin
                if ((ram_rdata & gright_reg) == '0)
                    skipped_next = 1'b1;
            end
            S_EXEC:
            begin
                case (mode_reg)
                    MODE_CREATE_OBJ:
                    begin
                        if (obj_lu.hit)
                            status_next = STAT_EXISTS;
                        else if (obj_full)
                            status_next = STAT_FULL;
                        else
                        begin
                            obj_wr   = 1'b1;
                            tgt_next = SWEEP_IW'(obj_new_idx);
                            row_next = 1'b0;
                        end
                    end
                    MODE_CREATE_SUBJ:
                    begin
                        if (subj_lu.hit)
                            status_next = STAT_EXISTS;
                        else if (subj_full)
                            status_next = STAT_FULL;
                        else
                        begin
                            subj_wr  = 1'b1;
                            tgt_next = SWEEP_IW'(subj_new_idx);
                            row_next = 1'b1;
                        end
                    end
                    MODE_DESTROY_OBJ:
                    begin
                        if (!obj_lu.hit)
                            status_next = STAT_NO_OBJ;
                        tgt_next = SWEEP_IW'(obj_lu.idx);
                        row_next = 1'b0;
                    end
                    MODE_DESTROY_SUBJ:
                    begin
                        if (!subj_lu.hit)
                            status_next = STAT_NO_SUBJ;
                        tgt_next = SWEEP_IW'(subj_lu.idx);
                        row_next = 1'b1;
                    end
                    MODE_ENTER, MODE_DELETE, MODE_CHECK:
                    begin
                        if (!subj_lu.hit)
                            status_next = STAT_NO_SUBJ;
                        else if (!obj_lu.hit)
                            status_next = STAT_NO_OBJ;
                        else
                        begin
                            ram_re     = 1'b1;
                            caddr_next = pair_addr;
                        end
                    end
                    default: ;
                endcase
            end
            S_CELL:
            begin
                case (mode_reg)
                    MODE_ENTER:
                    begin
                        cell_next = ram_rdata | mask_reg;
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata | mask_reg;
                    end
                    MODE_DELETE:
                    begin
                        cell_next = ram_rdata & ~mask_reg;
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata & ~mask_reg;
                    end
                    default:
                    begin
                        cell_next    = ram_rdata;
                        granted_next = (ram_rdata & mask_reg) != '0;
                    end
                endcase
            end
            S_CLEAR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = '0;
                ram_waddr  = row_reg ? cell_addr(SUBJ_IW'(tgt_reg), OBJ_IW'(sweep_reg))
                                     : cell_addr(SUBJ_IW'(sweep_reg), OBJ_IW'(tgt_reg));
                sweep_next = SWEEP_IW'(sweep_reg + 1'b1);
            end
            S_DONE: ;
            default: ;
        endcase
    end

    assign out_data_next  = out_load
                            ? {7'b0, cell_reg, skipped_reg, granted_reg, status_reg}
                            : out_data_reg;
    assign out_valid_next = out_load || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= s_axis_tdata[2:0];
            sid_reg    <= s_axis_tdata[3 +: ID_WIDTH];
            oid_reg    <= s_axis_tdata[19 +: ID_WIDTH];
            mask_reg   <= s_axis_tdata[38:35];
            gon_reg    <= s_axis_tdata[39];
            gright_reg <= s_axis_tdata[43:40];
            gsid_reg   <= s_axis_tdata[44 +: ID_WIDTH];
            goid_reg   <= s_axis_tdata[60 +: ID_WIDTH];
        end
        status_reg   <= status_next;
        granted_reg  <= granted_next;
        skipped_reg  <= skipped_next;
        cell_reg     <= cell_next;
        sweep_reg    <= sweep_next;
        tgt_reg      <= tgt_next;
        row_reg      <= row_next;
        caddr_reg    <= caddr_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `AMX_ASSERT(a_ram_we_state, ram_we |-> (state_reg == S_CELL || state_reg == S_CLEAR), "rights write outside write states")
    `AMX_ASSERT(a_accept_leaves_idle, accept |=> (state_reg != S_IDLE), "accepted beat did not start a command")
    `AMX_ASSERT(a_done_holds, (state_reg == S_DONE && m_axis_tvalid && !m_axis_tready) |=> (state_reg == S_DONE), "result overwrote a waiting beat")
    `AMX_ASSERT(a_guard_only_if_on, (state_reg == S_GUARD) |-> gon_reg, "guard run without guard_on")

endmodule
